/* src/bqrgb_pkg.sv */
// Shared types, constants and gamma threshold builder for the Bayer quad preview block.
package bqrgb_pkg;

   localparam int NUM_POS   = 4;
   localparam int NUM_CHAN  = 3;
   localparam int SAMPLE_W  = 16;
   localparam int NORM_W    = 20;
   localparam int GAIN_W    = 16;
   localparam int CODE_W    = 8;
   localparam int THR_W     = 16;
   localparam int NUM_CODES = 256;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;
   localparam logic [NORM_W-1:0] NORM_MAX = 20'hFFFFF;

   // sRGB code thresholds: linear segment and power segment constants
   localparam int unsigned LinCodes = 10;
   localparam int unsigned LinNum   = 100;
   localparam int unsigned LinDen   = 658920;
   localparam int unsigned PowBase  = 538050;

   typedef enum logic [1:0] {
      CH_RED,
      CH_GREEN,
      CH_BLUE
   } chan_type;

   typedef enum logic [2:0] {
      REG_CFA,
      REG_BLACK_TOP,
      REG_BLACK_BOTTOM,
      REG_WHITE,
      REG_GAIN_RED,
      REG_GAIN_GREEN,
      REG_GAIN_BLUE
   } reg_index_type;

   typedef chan_type route_row_type [NUM_POS];
   typedef route_row_type route_tab_type [4];

   // Channel of each quad position (TL, TR, BL, BR) for RGGB, GRBG, GBRG, BGGR
   localparam route_tab_type CFA_ROUTE = '{
      '{CH_RED,   CH_GREEN, CH_GREEN, CH_BLUE },
      '{CH_GREEN, CH_RED,   CH_BLUE,  CH_GREEN},
      '{CH_GREEN, CH_BLUE,  CH_RED,   CH_GREEN},
      '{CH_BLUE,  CH_GREEN, CH_GREEN, CH_RED  }
   };

   typedef logic [THR_W-1:0] thr_tab_type [NUM_CODES];
   typedef logic [319:0] big_type;

   function automatic big_type big_pow(input big_type b, input int n);
      big_type r;
      r = 320'd1;
      for (int t = 0; t < n; t++) begin
         r = r * b;
      end
      return r;
   endfunction

   // Smallest table index that reaches each 8-bit code; m+1 where none does.
   function automatic thr_tab_type build_thr(input int unsigned m);
      thr_tab_type tab;
      big_type     kbig;
      big_type     mb5;
      big_type     rhs;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned a;
      int unsigned num;
      kbig = big_pow(320'(PowBase), 12);
      mb5  = big_pow(320'(m), 5);
      tab[0] = '0;
      for (int k = 1; k < NUM_CODES; k++) begin
         if (k <= LinCodes) begin
            num = (2 * k - 1) * LinNum * m;
            tab[k] = THR_W'((num + LinDen - 1) / LinDen);
         end else begin
            a   = (2 * k - 1) * 1000 + 28050;
            rhs = big_pow(320'(a), 12) * mb5;
            lo  = 0;
            hi  = m + 1;
            while (lo < hi) begin
               mid = (lo + hi) >> 1;
               if (big_pow(320'(mid), 5) * kbig >= rhs) begin
                  hi = mid;
               end else begin
                  lo = mid + 1;
               end
            end
            tab[k] = THR_W'(lo);
         end
      end
      return tab;
   endfunction

endpackage

/* src/bayer_quad_to_rgb_preview.sv */
// Bayer quad to 8-bit sRGB preview pixel: normalize, demosaic, white balance, gamma.
// Stage order: black level, divide, channel average, gain, table index, threshold search.
// Throughput: one quad per cycle while the output is open; the 20-bit normalizing divide
// runs 4 quotient bits in each of five stages and the gamma lookup runs an 8-step
// threshold search, one step a stage. A full stage holds while its successor stalls; bubbles close up.
// Reset (synchronous, active high) empties the pipe and restores the register defaults.
module bayer_quad_to_rgb_preview #(
   parameter int GAMMA_INDEX_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // sample_top_left, sample_top_right, sample_bottom_left, sample_bottom_right
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red, green, blue
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IB       = GAMMA_INDEX_BITS;
   localparam int unsigned IDX_MAX = (1 << IB) - 1;
   localparam int X_W      = 29;
   localparam int P_W      = X_W + IB + 1;
   localparam int DIV_ST   = 5;
   localparam int SRCH_ST  = bqrgb_pkg::CODE_W;
   localparam int ST_AVG   = 1 + DIV_ST;
   localparam int ST_MUL   = ST_AVG + 1;
   localparam int ST_IDX   = ST_MUL + 1;
   localparam int ST_SRCH  = ST_IDX + 1;
   localparam int NS       = ST_SRCH + SRCH_ST;

   localparam bqrgb_pkg::thr_tab_type THR = bqrgb_pkg::build_thr(IDX_MAX);

   // ---------------- configuration registers ----------------
   logic [1:0]  cfa_ff;
   logic [31:0] blk_top_ff;
   logic [31:0] blk_bot_ff;
   logic [15:0] white_ff;
   logic [15:0] gain_ff [bqrgb_pkg::NUM_CHAN];
   logic        csr_wr;
   bqrgb_pkg::reg_index_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = bqrgb_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfa_ff     <= '0;
         blk_top_ff <= '0;
         blk_bot_ff <= '0;
         white_ff   <= 16'hFFFF;
         for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
            gain_ff[c] <= bqrgb_pkg::GAIN_ONE;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            bqrgb_pkg::REG_CFA:          cfa_ff <= csr_pwdata[1:0];
            bqrgb_pkg::REG_BLACK_TOP:    blk_top_ff <= csr_pwdata;
            bqrgb_pkg::REG_BLACK_BOTTOM: blk_bot_ff <= csr_pwdata;
            bqrgb_pkg::REG_WHITE:        white_ff <= csr_pwdata[15:0];
            bqrgb_pkg::REG_GAIN_RED:     gain_ff[bqrgb_pkg::CH_RED] <= csr_pwdata[15:0];
            bqrgb_pkg::REG_GAIN_GREEN:   gain_ff[bqrgb_pkg::CH_GREEN] <= csr_pwdata[15:0];
            bqrgb_pkg::REG_GAIN_BLUE:    gain_ff[bqrgb_pkg::CH_BLUE] <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         bqrgb_pkg::REG_CFA:          csr_prdata = {30'd0, cfa_ff};
         bqrgb_pkg::REG_BLACK_TOP:    csr_prdata = blk_top_ff;
         bqrgb_pkg::REG_BLACK_BOTTOM: csr_prdata = blk_bot_ff;
         bqrgb_pkg::REG_WHITE:        csr_prdata = {16'd0, white_ff};
         bqrgb_pkg::REG_GAIN_RED:     csr_prdata = {16'd0, gain_ff[bqrgb_pkg::CH_RED]};
         bqrgb_pkg::REG_GAIN_GREEN:   csr_prdata = {16'd0, gain_ff[bqrgb_pkg::CH_GREEN]};
         bqrgb_pkg::REG_GAIN_BLUE:    csr_prdata = {16'd0, gain_ff[bqrgb_pkg::CH_BLUE]};
         default:                     csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   logic v_ff [NS];
   logic rdy  [NS+1];

   always_comb begin
      rdy[NS] = rsp_tready;
      for (int s = NS - 1; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else begin
         if (rdy[0]) v_ff[0] <= req_tvalid;
         for (int s = 1; s < NS; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = v_ff[NS-1];

   // ---------------- stage 0: black level and range ----------------
   logic [15:0] blk [bqrgb_pkg::NUM_POS];
   logic [15:0] samp [bqrgb_pkg::NUM_POS];
   logic [15:0] d_in [bqrgb_pkg::NUM_POS];
   logic [15:0] rng_in [bqrgb_pkg::NUM_POS];
   logic [15:0] d_ff [bqrgb_pkg::NUM_POS];
   logic [15:0] rng_ff [bqrgb_pkg::NUM_POS];

   assign blk[0] = blk_top_ff[15:0];
   assign blk[1] = blk_top_ff[31:16];
   assign blk[2] = blk_bot_ff[15:0];
   assign blk[3] = blk_bot_ff[31:16];

   always_comb begin
      for (int p = 0; p < bqrgb_pkg::NUM_POS; p++) begin
         samp[p]   = req_tdata[16*p +: 16];
         d_in[p]   = (samp[p] > blk[p]) ? samp[p] - blk[p] : 16'd0;
         rng_in[p] = (white_ff > blk[p]) ? white_ff - blk[p] : 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         d_ff   <= d_in;
         rng_ff <= rng_in;
      end
   end

   // ---------------- stages 1..5: restoring divide, 4 bits a stage ----------------
   function automatic logic [19:0] div_step4(input logic [15:0] r, input logic [15:0] rng,
                                              input logic [3:0] nb);
      logic [16:0] t;
      logic [15:0] rr;
      logic [3:0]  q;
      rr = r;
      for (int i = 3; i >= 0; i--) begin
         t = {rr, nb[i]};
         if (t >= {1'b0, rng}) begin
            rr   = 16'(t - {1'b0, rng});
            q[i] = 1'b1;
         end else begin
            rr   = t[15:0];
            q[i] = 1'b0;
         end
      end
      return {rr, q};
   endfunction

   logic [15:0] dv_r_ff   [DIV_ST][bqrgb_pkg::NUM_POS];
   logic [19:0] dv_q_ff   [DIV_ST][bqrgb_pkg::NUM_POS];
   logic [15:0] dv_rng_ff [DIV_ST][bqrgb_pkg::NUM_POS];
   logic        dv_sat_ff [DIV_ST][bqrgb_pkg::NUM_POS];

   for (genvar k = 0; k < DIV_ST; k++) begin : g_div
      logic [15:0] r_src   [bqrgb_pkg::NUM_POS];
      logic [19:0] q_src   [bqrgb_pkg::NUM_POS];
      logic [15:0] rng_src [bqrgb_pkg::NUM_POS];
      logic        sat_src [bqrgb_pkg::NUM_POS];
      logic [3:0]  nb_src  [bqrgb_pkg::NUM_POS];
      logic [19:0] step    [bqrgb_pkg::NUM_POS];

      if (k == 0) begin : g_src
         always_comb begin
            for (int p = 0; p < bqrgb_pkg::NUM_POS; p++) begin
               r_src[p]   = {4'd0, d_ff[p][15:4]};
               q_src[p]   = '0;
               rng_src[p] = rng_ff[p];
               // quotient reaches 2^20 when d >= 16 * range
               sat_src[p] = {4'd0, d_ff[p]} >= {rng_ff[p], 4'd0};
               nb_src[p]  = d_ff[p][3:0];
            end
         end
      end else begin : g_src
         always_comb begin
            for (int p = 0; p < bqrgb_pkg::NUM_POS; p++) begin
               r_src[p]   = dv_r_ff[k-1][p];
               q_src[p]   = dv_q_ff[k-1][p];
               rng_src[p] = dv_rng_ff[k-1][p];
               sat_src[p] = dv_sat_ff[k-1][p];
               nb_src[p]  = 4'd0;
            end
         end
      end

      always_comb begin
         for (int p = 0; p < bqrgb_pkg::NUM_POS; p++) begin
            step[p] = div_step4(r_src[p], rng_src[p], nb_src[p]);
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k+1]) begin
            for (int p = 0; p < bqrgb_pkg::NUM_POS; p++) begin
               dv_r_ff[k][p]   <= step[p][19:4];
               dv_q_ff[k][p]   <= {q_src[p][15:0], step[p][3:0]};
               dv_rng_ff[k][p] <= rng_src[p];
               dv_sat_ff[k][p] <= sat_src[p];
            end
         end
      end
   end

   // ---------------- stage 6: route to channels and average ----------------
   logic [19:0] norm [bqrgb_pkg::NUM_POS];
   logic [20:0] csum [bqrgb_pkg::NUM_CHAN];
   logic [1:0]  ccnt [bqrgb_pkg::NUM_CHAN];
   logic [19:0] av_ff [bqrgb_pkg::NUM_CHAN];

   always_comb begin
      for (int p = 0; p < bqrgb_pkg::NUM_POS; p++) begin
         norm[p] = dv_sat_ff[DIV_ST-1][p] ? bqrgb_pkg::NORM_MAX : dv_q_ff[DIV_ST-1][p];
      end
      for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
         csum[c] = '0;
         ccnt[c] = '0;
         for (int p = 0; p < bqrgb_pkg::NUM_POS; p++) begin
            if (bqrgb_pkg::CFA_ROUTE[cfa_ff][p] == bqrgb_pkg::chan_type'(c)) begin
               csum[c] = csum[c] + {1'b0, norm[p]};
               ccnt[c] = ccnt[c] + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_AVG]) begin
         for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
            av_ff[c] <= (ccnt[c] > 2'd1) ? csum[c][20:1] : csum[c][19:0];
         end
      end
   end

   // ---------------- stage 7: white-balance gain ----------------
   logic [35:0] mul_ff [bqrgb_pkg::NUM_CHAN];

   always_ff @(posedge clock) begin
      if (rdy[ST_MUL]) begin
         for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
            mul_ff[c] <= av_ff[c] * ((gain_ff[c] == '0) ? bqrgb_pkg::GAIN_ONE : gain_ff[c]);
         end
      end
   end

   // ---------------- stage 8: clamp and quantize to a table index ----------------
   logic [X_W-1:0] xcl [bqrgb_pkg::NUM_CHAN];
   logic [P_W-1:0] prod [bqrgb_pkg::NUM_CHAN];
   logic [IB-1:0]  ix_ff [bqrgb_pkg::NUM_CHAN];

   always_comb begin
      for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
         xcl[c]  = (mul_ff[c] > 36'h010000000) ? X_W'(36'h010000000) : mul_ff[c][X_W-1:0];
         // x * (2^IB - 1) as shift and subtract, then round at bit 27
         prod[c] = ({1'b0, xcl[c], IB'(0)} - P_W'(xcl[c])) + P_W'(28'h8000000);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_IDX]) begin
         for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
            ix_ff[c] <= prod[c][28 +: IB];
         end
      end
   end

   // ---------------- stages 9..16: threshold search, one code bit a stage ----------------
   logic [7:0]    sr_code_ff [SRCH_ST][bqrgb_pkg::NUM_CHAN];
   logic [IB-1:0] sr_ix_ff   [SRCH_ST][bqrgb_pkg::NUM_CHAN];

   for (genvar j = 0; j < SRCH_ST; j++) begin : g_srch
      logic [7:0]    code_src [bqrgb_pkg::NUM_CHAN];
      logic [IB-1:0] ix_src   [bqrgb_pkg::NUM_CHAN];
      logic [7:0]    cand     [bqrgb_pkg::NUM_CHAN];
      logic [7:0]    code_in  [bqrgb_pkg::NUM_CHAN];

      if (j == 0) begin : g_src
         always_comb begin
            for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
               code_src[c] = '0;
               ix_src[c]   = ix_ff[c];
            end
         end
      end else begin : g_src
         always_comb begin
            for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
               code_src[c] = sr_code_ff[j-1][c];
               ix_src[c]   = sr_ix_ff[j-1][c];
            end
         end
      end

      always_comb begin
         for (int c = 0; c < bqrgb_pkg::NUM_CHAN; c++) begin
            cand[c]    = code_src[c] | (8'd1 << (SRCH_ST - 1 - j));
            code_in[c] = (THR[cand[c]] <= bqrgb_pkg::THR_W'(ix_src[c])) ? cand[c] : code_src[c];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[ST_SRCH+j]) begin
            sr_code_ff[j] <= code_in;
            sr_ix_ff[j]   <= ix_src;
         end
      end
   end

   assign rsp_tdata = {sr_code_ff[SRCH_ST-1][bqrgb_pkg::CH_BLUE],
                       sr_code_ff[SRCH_ST-1][bqrgb_pkg::CH_GREEN],
                       sr_code_ff[SRCH_ST-1][bqrgb_pkg::CH_RED]};

endmodule

/* src/bqrgb_check.sv */
// Port-level checker for the Bayer quad preview block, bound to its top level.
module bqrgb_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_pready
);

   // pipe is empty the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present right after reset");

   // a stalled result beat holds
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed or dropped");

   // an open output lets every stage advance
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output is open");

   // an empty last stage means the pipe can take a beat
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output stage");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind bayer_quad_to_rgb_preview bqrgb_check u_bqrgb_check (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

/* dv/tb_bayer_quad_to_rgb_preview.sv */
// Self-checking testbench for the Bayer quad to sRGB preview block.
`timescale 1ns / 1ps

module tb_bayer_quad_to_rgb_preview;

   localparam int IDX_BITS = 12;
   localparam int IDX_MAX  = (1 << IDX_BITS) - 1;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT = 40;

   typedef logic [319:0] wide_type;

   class pixel_scoreboard;
      bit [1:0]  cfa;
      bit [31:0] black_top;
      bit [31:0] black_bot;
      bit [15:0] white;
      bit [15:0] gain [3];
      bit [7:0]  srgb_lut [1 << IDX_BITS];
      bit [23:0] pixels_due [$];

      function wide_type wide_pow(wide_type b, int n);
         wide_type r;
         r = 1;
         for (int t = 0; t < n; t++) r = r * b;
         return r;
      endfunction

      // Count the code thresholds each index reaches, compared exactly.
      function void build_lut();
         wide_type base12;
         wide_type m5;
         wide_type lhs;
         wide_type thr [256];
         int unsigned code;
         base12 = wide_pow(wide_type'(538050), 12);
         m5 = wide_pow(wide_type'(IDX_MAX), 5);
         for (int k = 11; k < 256; k++)
            thr[k] = wide_pow(wide_type'((2 * k - 1) * 1000 + 28050), 12) * m5;
         for (int i = 0; i <= IDX_MAX; i++) begin
            code = 0;
            for (int k = 1; k <= 10; k++)
               if (64'(i) * 64'd658920 >= 64'((2 * k - 1) * 100) * 64'(IDX_MAX)) code++;
            lhs = wide_pow(wide_type'(i), 5) * base12;
            for (int k = 11; k < 256; k++)
               if (lhs >= thr[k]) code++;
            srgb_lut[i] = code[7:0];
         end
      endfunction

      function new();
         cfa = 0;
         black_top = 0;
         black_bot = 0;
         white = 16'hFFFF;
         for (int c = 0; c < 3; c++) gain[c] = 16'd4096;
         build_lut();
      endfunction

      function bit [19:0] normalize(bit [15:0] s, bit [15:0] blk);
         bit [63:0] rng;
         bit [63:0] q;
         if (s <= blk) return 0;
         rng = (white > blk) ? 64'(white - blk) : 64'd1;
         q = (64'(s - blk) << 16) / rng;
         return (q > 64'hFFFFF) ? 20'hFFFFF : q[19:0];
      endfunction

      function void note_quad(bit [63:0] quad);
         bit [15:0] blk [4];
         bit [31:0] sum [3];
         int        cnt [3];
         bit [31:0] v;
         bit [63:0] x;
         bit [63:0] idx;
         bit [15:0] g;
         bit [23:0] pix;
         bqrgb_pkg::chan_type ch;
         blk[0] = black_top[15:0];
         blk[1] = black_top[31:16];
         blk[2] = black_bot[15:0];
         blk[3] = black_bot[31:16];
         for (int c = 0; c < 3; c++) begin
            sum[c] = 0;
            cnt[c] = 0;
         end
         for (int p = 0; p < 4; p++) begin
            ch = bqrgb_pkg::CFA_ROUTE[cfa][p];
            sum[ch] += normalize(quad[16*p +: 16], blk[p]);
            cnt[ch]++;
         end
         for (int c = 0; c < 3; c++) begin
            v = (cnt[c] > 1) ? (sum[c] >> 1) : sum[c];
            g = (gain[c] == 0) ? 16'd4096 : gain[c];
            x = 64'(v) * 64'(g);
            if (x > (64'd1 << 28)) x = 64'd1 << 28;
            idx = (x * IDX_MAX + (64'd1 << 27)) >> 28;
            pix[8*c +: 8] = srgb_lut[idx];
         end
         pixels_due.push_back(pix);
      endfunction

      function bit check_pixel(bit [23:0] got, output string msg);
         bit [23:0] want;
         string names [3];
         names = '{"red", "green", "blue"};
         msg = "";
         if (pixels_due.size() == 0) begin
            msg = $sformatf("unexpected pixel %h", got);
            return 0;
         end
         want = pixels_due.pop_front();
         for (int c = 0; c < 3; c++)
            if (got[8*c +: 8] != want[8*c +: 8])
               msg = {msg, $sformatf(" %s got %0d want %0d", names[c],
                                     got[8*c +: 8], want[8*c +: 8])};
         return msg == "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // sample_top_left, top_right, bottom_left, bottom_right
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;        // red, green, blue
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pixel_scoreboard sb;
   int errors = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_phase = 0;

   bayer_quad_to_rgb_preview uut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   task report(input string msg);
      $display("MISMATCH @%0t:%s", $realtime, msg);
      errors++;
   endtask

   task csr_write(input bqrgb_pkg::reg_index_type idx, input bit [31:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= 5'(idx * 4);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      case (idx)
         bqrgb_pkg::REG_CFA:          sb.cfa = val[1:0];
         bqrgb_pkg::REG_BLACK_TOP:    sb.black_top = val;
         bqrgb_pkg::REG_BLACK_BOTTOM: sb.black_bot = val;
         bqrgb_pkg::REG_WHITE:        sb.white = val[15:0];
         bqrgb_pkg::REG_GAIN_RED:     sb.gain[bqrgb_pkg::CH_RED] = val[15:0];
         bqrgb_pkg::REG_GAIN_GREEN:   sb.gain[bqrgb_pkg::CH_GREEN] = val[15:0];
         bqrgb_pkg::REG_GAIN_BLUE:    sb.gain[bqrgb_pkg::CH_BLUE] = val[15:0];
         default: ;
      endcase
   endtask

   // Close the current burst, then wait until every due pixel is out.
   task drain();
      req_tvalid <= 0;
      burst_left = 0;
      while (sb.pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task write_all(input bit [1:0] cfa, input bit [31:0] bt, input bit [31:0] bb,
                  input bit [15:0] wl, input bit [15:0] gr, input bit [15:0] gg,
                  input bit [15:0] gb);
      drain();
      csr_write(bqrgb_pkg::REG_CFA, 32'(cfa));
      csr_write(bqrgb_pkg::REG_BLACK_TOP, bt);
      csr_write(bqrgb_pkg::REG_BLACK_BOTTOM, bb);
      csr_write(bqrgb_pkg::REG_WHITE, 32'(wl));
      csr_write(bqrgb_pkg::REG_GAIN_RED, 32'(gr));
      csr_write(bqrgb_pkg::REG_GAIN_GREEN, 32'(gg));
      csr_write(bqrgb_pkg::REG_GAIN_BLUE, 32'(gb));
   endtask

   // Bursts of back-to-back beats; lower valid only at a burst end.
   task send_quad(input bit [63:0] quad);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
      end
      req_tvalid <= 1;
      req_tdata <= quad;
      do @(posedge clock); while (!req_tready);
      sb.note_quad(quad);
      burst_left--;
      if (burst_left == 0) req_tvalid <= 0;
   endtask

   function bit [15:0] rand_sample(bit [15:0] blk);
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'(blk + $urandom_range(0, 64));
         default: return 16'(blk + $urandom_range(0, sb.white > blk ? sb.white - blk : 0));
      endcase
   endfunction

   task send_random_quad();
      bit [63:0] q;
      q[15:0]  = rand_sample(sb.black_top[15:0]);
      q[31:16] = rand_sample(sb.black_top[31:16]);
      q[47:32] = rand_sample(sb.black_bot[15:0]);
      q[63:48] = rand_sample(sb.black_bot[31:16]);
      send_quad(q);
   endtask

   function bit [15:0] rand_gain();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(2048, 12288));
      endcase
   endfunction

   // Receiver: free-running stretches, light and heavy stall stretches.
   always @(posedge clock) begin
      string msg;
      stall_phase <= stall_phase + 1;
      case ((stall_phase >> 7) % 4)
         0: rsp_tready <= 1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 4) == 0);
         default: rsp_tready <= ((stall_phase % 16) < 9);
      endcase
      if (!reset && rsp_tvalid && rsp_tready)
         if (!sb.check_pixel(rsp_tdata, msg)) report(msg);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      bit [15:0] bl;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 0;
      // Defaults: extremes and bit patterns.
      send_quad(64'h0);
      send_quad(64'hFFFF_FFFF_FFFF_FFFF);
      send_quad(64'h5555_AAAA_5555_AAAA);
      send_quad(64'hAAAA_5555_AAAA_5555);
      send_quad(64'h0001_0001_0001_0001);
      send_quad(64'h0080_0040_0020_0010);
      // Black levels per position, samples at, below and above them.
      write_all(2'd1, 32'h0200_0100, 32'h0400_0300, 16'd4095, 16'd4096, 16'd0, 16'd8192);
      send_quad(64'h0400_0300_0200_0100);
      send_quad(64'h03FF_02FF_01FF_00FF);
      send_quad(64'h0FFF_0FFF_0FFF_0FFF);
      send_quad(64'h0800_0700_0600_0500);
      // White not above black, white of zero, max gains.
      write_all(2'd2, 32'h8000_8000, 32'hFFFF_0000, 16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_quad(64'h8001_8001_8001_8001);
      send_quad(64'hFFFF_0001_7FFF_0000);
      write_all(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd1, 16'd1, 16'd1);
      send_quad(64'hFFFF_FFFF_FFFF_FFFF);
      send_quad(64'h1234_5678_9ABC_DEF0);
      write_all(2'd0, 32'h0, 32'h0, 16'd1, 16'd0, 16'd2048, 16'd0);
      send_quad(64'h0000_0001_0000_0001);
      send_quad(64'h0001_0000_0001_0000);
      // Random phases with random settings.
      for (int ph = 0; ph < 12; ph++) begin
         bl = (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
         write_all(2'($urandom_range(0, 3)),
                   {16'(bl + $urandom_range(0, 64)), bl},
                   (ph == 5) ? 32'hFFFF_FFFF : {16'(bl + $urandom_range(0, 64)), bl},
                   (ph == 7) ? 16'd1 : (ph % 4 == 1) ? 16'($urandom)
                                     : 16'($urandom_range(bl + 1, 65535)),
                   rand_gain(), rand_gain(), rand_gain());
         for (int n = 0; n < 125; n++) send_random_quad();
      end
      drain();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

/* filelist.f */
src/bqrgb_pkg.sv
src/bayer_quad_to_rgb_preview.sv
src/bqrgb_check.sv
dv/tb_bayer_quad_to_rgb_preview.sv
